FILE: hw/rtl/gsa_pkg.sv
`default_nettype none

package gsa_pkg;

  // slot and special code sizing
  localparam int NUM_SLOTS   = 8;
  localparam int NUM_SPECIAL = 32;

  localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int USED_W  = $clog2(NUM_SLOTS + 1);
  localparam int IDX_W   = (NUM_SPECIAL > 1) ? $clog2(NUM_SPECIAL) : 1;
  localparam int TOTAL_W = $clog2(NUM_SPECIAL + 1);

  // field widths
  localparam int CODE_W  = 8;
  localparam int SEL_W   = 3;
  localparam int COUNT_W = 6;

  localparam logic [CODE_W-1:0] SPECIAL_BASE = 8'h80;

  // stream widths; the tdata widths are rounded up to whole bytes
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 24;
  localparam int S_USER_W = 2;

  // request kinds carried on tuser
  typedef enum logic [S_USER_W-1:0] {
    REQ_CLEAR = 2'd0,
    REQ_SCAN  = 2'd1,
    REQ_MAP   = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  // one result item
  typedef struct packed {
    logic               overflow;
    logic [COUNT_W-1:0] distinct_count;
    logic               slot_valid;
    logic               slot_hit;
    logic [CODE_W-1:0]  out_code;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/glyph_slot_allocator_unit.sv
// Glyph slot allocator for a character display.
// Input channel s_*: one request per transaction; tuser carries the request
// kind (clear frame, scan, map, read slot), tdata the character code, the
// fallback code and the slot select. Output channel m_*: exactly one result
// transaction per request, in request order.
// A frame starts with a clear; scans then hand in the frame's characters and
// each new special code (0x80 upward) takes the next free slot. Map turns a
// special code into its slot number or the fallback, read returns the code
// held in a slot for loading the glyph RAM.
// The slot table compare, allocation and state update are done in the
// accepting cycle and the result lands in the output register. Throughput
// is one request per cycle while the receiver takes each result; the
// parallel compare covers all slots at once.
// The output register frees whenever the receiver takes its result, so a
// new request is accepted in the same cycle the previous result leaves.
// While the receiver stalls with a result pending, s_tready stays low and
// the state does not move.
// Reset (rst, synchronous) empties all slots, the seen set and the count,
// the same as a clear request, and drops any pending result.
`default_nettype none

module glyph_slot_allocator_unit (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           s_tvalid,
  output logic                          s_tready,
  // char_code[7:0], fallback_code[15:8], slot_sel[18:16], zero pad
  input  wire  [gsa_pkg::S_DATA_W-1:0]  s_tdata,
  // req_type[1:0]
  input  wire  [gsa_pkg::S_USER_W-1:0]  s_tuser,
  output logic                          m_tvalid,
  input  wire                           m_tready,
  // out_code[7:0], slot_hit[8], slot_valid[9], distinct_count[15:10],
  // overflow[16], zero pad
  output logic [gsa_pkg::M_DATA_W-1:0]  m_tdata
);

  import gsa_pkg::*;

  // frame state
  logic [IDX_W-1:0]   slot_glyph [NUM_SLOTS];
  logic [IDX_W-1:0]   slot_glyph_next [NUM_SLOTS];
  logic [USED_W-1:0]  slots_used, slots_used_next;
  logic [NUM_SPECIAL-1:0] seen_mask, seen_mask_next;
  logic [TOTAL_W-1:0] seen_total, seen_total_next;

  result_t            result, result_next;

  // unpacked request fields
  req_t               req;
  logic [CODE_W-1:0]  char_code;
  logic [CODE_W-1:0]  fallback_code;
  logic [SEL_W-1:0]   slot_sel;

  logic               accept;
  logic               special;
  logic [IDX_W-1:0]   idx;
  logic [NUM_SLOTS-1:0] match;
  logic               found;
  logic [SLOT_W-1:0]  found_slot;
  logic               sel_valid;
  logic [IDX_W-1:0]   sel_glyph;

  assign req           = req_t'(s_tuser);
  assign char_code     = s_tdata[7:0];
  assign fallback_code = s_tdata[15:8];
  assign slot_sel      = s_tdata[18:16];

  // output register frees when its result is taken
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // special code range check
  assign special = char_code[7] &&
                   ({1'b0, char_code[6:0]} < CODE_W'(NUM_SPECIAL));
  assign idx     = char_code[IDX_W-1:0];

  // parallel compare over occupied slots, lowest slot wins
  always_comb begin
    match      = '0;
    found_slot = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      match[i] = (USED_W'(i) < slots_used) && (slot_glyph[i] == idx);
    end
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        found_slot = SLOT_W'(i);
      end
    end
  end
  assign found = special && (match != '0);

  // slot read select
  always_comb begin
    sel_glyph = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (CODE_W'(slot_sel) == CODE_W'(i)) begin
        sel_glyph = slot_glyph[i];
      end
    end
  end
  assign sel_valid = (CODE_W'(slot_sel) < CODE_W'(NUM_SLOTS)) &&
                     (CODE_W'(slot_sel) < CODE_W'(slots_used));

  // request decode, state update and result
  always_comb begin
    slot_glyph_next = slot_glyph;
    slots_used_next = slots_used;
    seen_mask_next  = seen_mask;
    seen_total_next = seen_total;
    result_next     = '0;
    unique case (req)
      REQ_CLEAR: begin
        slots_used_next = '0;
        seen_mask_next  = '0;
        seen_total_next = '0;
      end
      REQ_SCAN: begin
        if (found) begin
          result_next.out_code = CODE_W'(found_slot);
          result_next.slot_hit = 1'b1;
        end else if (special && !seen_mask[idx]) begin
          seen_mask_next[idx] = 1'b1;
          if (seen_total < TOTAL_W'(NUM_SPECIAL)) begin
            seen_total_next = seen_total + TOTAL_W'(1);
          end
          if (slots_used < USED_W'(NUM_SLOTS)) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
              if (USED_W'(i) == slots_used) begin
                slot_glyph_next[i] = idx;
              end
            end
            result_next.out_code = CODE_W'(slots_used);
            result_next.slot_hit = 1'b1;
            slots_used_next      = slots_used + USED_W'(1);
          end
        end
      end
      REQ_MAP: begin
        if (!special) begin
          result_next.out_code = char_code;
        end else if (found) begin
          result_next.out_code = CODE_W'(found_slot);
          result_next.slot_hit = 1'b1;
        end else begin
          result_next.out_code = fallback_code;
        end
      end
      REQ_READ: begin
        if (sel_valid) begin
          result_next.slot_valid = 1'b1;
          result_next.out_code   = SPECIAL_BASE + CODE_W'(sel_glyph);
        end
      end
      default: begin
        result_next = '0;
      end
    endcase
    result_next.distinct_count = COUNT_W'(seen_total_next);
    result_next.overflow       = CODE_W'(seen_total_next) > CODE_W'(NUM_SLOTS);
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_used <= '0;
      seen_mask  <= '0;
      seen_total <= '0;
    end else if (accept) begin
      slots_used <= slots_used_next;
      seen_mask  <= seen_mask_next;
      seen_total <= seen_total_next;
    end
  end

  // slot table, guarded by slots_used so no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      slot_glyph <= slot_glyph_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign m_tdata = M_DATA_W'(result);

endmodule

`default_nettype wire
